// File: design/mwfs_pkg.sv
// ----------------------------------------------------------------------------
// mwfs_pkg
// Shared types and constants of the multipath water-filling scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mwfs_pkg;

	localparam int MAX_PATHS   = 4;
	localparam int MAX_PACKETS = 64;
	localparam int PIW = $clog2(MAX_PATHS);
	localparam int PCW = $clog2(MAX_PATHS + 1);
	localparam int KIW = $clog2(MAX_PACKETS);
	localparam int KCW = $clog2(MAX_PACKETS + 1);

	localparam int MUL_A_W  = 48;
	localparam int MUL_B_W  = 48;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int MD_CNT_W = $clog2(MUL_A_W + 1);
	localparam int QUOTA_W  = 33;
	localparam int SUM_W    = QUOTA_W + PCW;
	localparam int SRCH_W   = 40;
	localparam int PKT_W    = 48;

	localparam logic [12:0] KBYTE_BITS = 13'd8000;
	localparam logic [QUOTA_W-1:0] QUOTA_MAX = {QUOTA_W{1'b1}};
	// product at or above 8000 * 2^33 gives a saturated quota
	localparam logic [PROD_W-1:0] SAT_PROD = PROD_W'(64'd68719476736000);
	// x / 8000 == (x * RECIP_KBYTE) >> RECIP_SH, exact for every x below SAT_PROD
	localparam int RECIP_SH = 59;
	localparam logic [MUL_B_W-1:0] RECIP_KBYTE = MUL_B_W'(64'd72057594037928);

	localparam logic [1:0] MODE_PATH = 2'd0;
	localparam logic [1:0] MODE_PKT  = 2'd1;
	localparam logic [1:0] MODE_GO   = 2'd2;

	typedef enum logic [1:0] {
		MD_MUL = 2'b01,
		MD_DIV = 2'b10
	} md_op_t;

	typedef struct packed {
		logic                start;
		md_op_t              op;
		logic [MUL_A_W-1:0]  a;
		logic [MUL_B_W-1:0]  b;
	} md_req_t;

	typedef struct packed {
		logic               done;
		logic [PROD_W-1:0]  value;
	} md_rsp_t;

endpackage

`default_nettype wire

// File: design/multipath_water_filling_scheduler.sv
// ----------------------------------------------------------------------------
// multipath_water_filling_scheduler
// Loads path and packet records, then on a go transaction assigns every
// packet to a path by delay-based water filling.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  item    | item_valid / item_stall     | mode, path_*, packet_*, frame_bytes
//  result  | result_valid / result_stall | out_packet_id, out_path_id, no_path, last
//
//  Path and packet records are taken one per cycle while idle. A go with packets
//  sorts the paths (one per cycle) unless one path is loaded; with a usable path and
//  two or more packets it binary-searches the fill depth; every probe does one
//  multiply, then per usable path a multiply and a reciprocal multiply by 1/8000,
//  all on the shared bit-serial unit; the drain emits each packet as the result
//  slot frees. item_stall is high from go until the last result is registered.
//  Reset clears the counts and control; the tables are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module multipath_water_filling_scheduler
	import mwfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  path_id,
	input  wire logic [15:0] path_delay_ms,
	input  wire logic [31:0] path_rate_bps,
	input  wire logic [31:0] packet_id,
	input  wire logic [15:0] packet_bytes,
	input  wire logic [23:0] frame_bytes,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [31:0]      out_packet_id,
	output logic [7:0]       out_path_id,
	output logic             no_path,
	output logic             last
);

	typedef enum logic [17:0] {
		S_IDLE      = 18'h00001,
		S_SORT      = 18'h00002,
		S_LEN_RD    = 18'h00004,
		S_LEN_WAIT  = 18'h00008,
		S_STEP_GO   = 18'h00010,
		S_STEP_WAIT = 18'h00020,
		S_PROD_GO   = 18'h00040,
		S_PROD_WAIT = 18'h00080,
		S_HI_GO     = 18'h00100,
		S_HI_WAIT   = 18'h00200,
		S_SEARCH    = 18'h00400,
		S_EXTRA     = 18'h00800,
		S_FILL_GO   = 18'h01000,
		S_FILL_WAIT = 18'h02000,
		S_QDIV_WAIT = 18'h04000,
		S_ACC       = 18'h08000,
		S_EMIT_RD   = 18'h10000,
		S_EMIT_DEC  = 18'h20000
	} state_t;

	typedef enum logic [1:0] {
		K_SINGLE,
		K_NONE,
		K_FIRST,
		K_DRAIN
	} kind_t;

	state_t state_q;
	kind_t  kind_q;

	logic [PCW-1:0] path_count_q;
	logic [KCW-1:0] pkt_count_q;
	logic [PCW-1:0] nq_q;
	logic [PCW-1:0] nu_q;
	logic [KCW-1:0] np_q;
	logic [PCW-1:0] k_q;
	logic [PCW-1:0] h_q;
	logic [KCW-1:0] pk_q;
	logic [23:0]    frame_q;

	logic [7:0]         p_id_q    [MAX_PATHS];
	logic [15:0]        p_delay_q [MAX_PATHS];
	logic [31:0]        p_rate_q  [MAX_PATHS];
	logic [7:0]         s_id_q    [MAX_PATHS];
	logic [15:0]        s_delay_q [MAX_PATHS];
	logic [31:0]        s_rate_q  [MAX_PATHS];
	logic [QUOTA_W-1:0] quota_q   [MAX_PATHS];

	logic [15:0]        len_first_q;
	logic [31:0]        step_q;
	logic [31:0]        prod_q;
	logic [SRCH_W-1:0]  lo_q;
	logic [SRCH_W-1:0]  hi_q;
	logic [SRCH_W-1:0]  mid_q;
	logic               final_q;
	logic [PROD_W-1:0]  extra_q;
	logic [SUM_W-1:0]   sum_q;
	logic [QUOTA_W-1:0] q_q;

	logic        accept_in;
	logic        slot_free;
	md_req_t     md_req;
	md_rsp_t     md_rsp;
	logic [PKT_W-1:0] ram_rdata;
	logic        ram_we;
	logic        ram_re;
	logic [KIW-1:0] ram_raddr;

	assign item_stall = (state_q != S_IDLE);
	assign accept_in  = item_valid && !item_stall;
	assign slot_free  = !result_valid || !result_stall;

	assign ram_we    = accept_in && mode == MODE_PKT && pkt_count_q < KCW'(MAX_PACKETS);
	assign ram_re    = (state_q == S_LEN_RD) || (state_q == S_EMIT_RD);
	assign ram_raddr = (state_q == S_LEN_RD) ? '0 : pk_q[KIW-1:0];

	mwfs_ram #(
		.WIDTH(PKT_W),
		.DEPTH(MAX_PACKETS)
	) u_pkt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pkt_count_q[KIW-1:0]),
		.wdata ({packet_id, packet_bytes}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mwfs_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// insertion point of the path under sort: entries with larger delay shift up
	logic [PIW-1:0]   kidx;
	logic [PIW-1:0]   slow_idx;
	logic [MAX_PATHS-1:0] gt;
	logic [15:0]      maxd;
	logic [15:0]      delta;
	logic [MUL_A_W-1:0] diff;
	logic [MUL_A_W:0] diff_sum;
	logic [MUL_A_W-1:0] hi_num;
	logic [SRCH_W-1:0]  mid_n;
	logic [SUM_W-1:0]   sum_n;
	logic [QUOTA_W:0]   remain;
	logic               keep_path;
	logic               last_path;
	logic               skip_path;
	logic               emit;

	assign kidx     = k_q[PIW-1:0];
	assign slow_idx = PIW'(nu_q - PCW'(1));
	assign maxd     = s_delay_q[slow_idx];
	assign delta    = maxd - s_delay_q[kidx];
	assign diff_sum = (MUL_A_W + 1)'(extra_q[MUL_A_W-1:0]) + (MUL_A_W + 1)'(delta);
	assign diff     = (|extra_q[PROD_W-1:MUL_A_W] || diff_sum[MUL_A_W]) ?
		{MUL_A_W{1'b1}} : diff_sum[MUL_A_W-1:0];
	assign hi_num   = MUL_A_W'(frame_q) * MUL_A_W'(KBYTE_BITS) + MUL_A_W'(prod_q) -
		MUL_A_W'(1);
	assign mid_n    = (lo_q < hi_q) ? lo_q + ((hi_q - lo_q) >> 1) : lo_q;
	assign sum_n    = sum_q + SUM_W'(q_q);
	assign remain   = {1'b0, quota_q[h_q[PIW-1:0]]} - (QUOTA_W + 1)'(ram_rdata[15:0]);
	assign keep_path = !remain[QUOTA_W] && remain[QUOTA_W-1:0] >= QUOTA_W'(len_first_q);
	assign last_path = (h_q + PCW'(1)) >= nu_q;
	// an emptied front path is dropped before the packet is placed
	assign skip_path = kind_q == K_DRAIN && !last_path && quota_q[h_q[PIW-1:0]] == '0;
	assign emit      = state_q == S_EMIT_DEC && slot_free && !skip_path;

	always_comb begin
		for (int j = 0; j < MAX_PATHS; j++) begin
			gt[j] = (PCW'(j) < nu_q) && (s_delay_q[j] > p_delay_q[kidx]);
		end
	end

	always_comb begin
		md_req       = '0;
		md_req.op    = MD_MUL;
		unique case (state_q)
			S_STEP_GO: begin
				md_req.start = 1'b1;
				md_req.op    = MD_DIV;
				md_req.a     = MUL_A_W'(len_first_q) * MUL_A_W'(KBYTE_BITS);
				md_req.b     = MUL_B_W'(s_rate_q[slow_idx]);
			end
			S_PROD_GO: begin
				md_req.start = 1'b1;
				md_req.a     = MUL_A_W'(step_q);
				md_req.b     = MUL_B_W'(s_rate_q[slow_idx]);
			end
			S_HI_GO: begin
				md_req.start = 1'b1;
				md_req.op    = MD_DIV;
				md_req.a     = hi_num;
				md_req.b     = MUL_B_W'(prod_q);
			end
			S_SEARCH: begin
				md_req.start = 1'b1;
				md_req.a     = MUL_A_W'(mid_n);
				md_req.b     = MUL_B_W'(step_q);
			end
			S_FILL_GO: begin
				md_req.start = 1'b1;
				md_req.a     = diff;
				md_req.b     = MUL_B_W'(s_rate_q[kidx]);
			end
			S_FILL_WAIT: begin
				// unsaturated product goes on to the reciprocal multiply
				md_req.start = md_rsp.done && md_rsp.value < SAT_PROD;
				md_req.a     = md_rsp.value[MUL_A_W-1:0];
				md_req.b     = RECIP_KBYTE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			path_count_q <= '0;
			pkt_count_q  <= '0;
			result_valid <= 1'b0;
		end else begin
			if (emit) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						if (mode == MODE_PATH && path_count_q < PCW'(MAX_PATHS)) begin
							path_count_q <= path_count_q + PCW'(1);
						end else if (ram_we) begin
							pkt_count_q <= pkt_count_q + KCW'(1);
						end else if (mode == MODE_GO) begin
							path_count_q <= '0;
							pkt_count_q  <= '0;
							if (pkt_count_q == '0) begin
								state_q <= S_IDLE;
							end else if (path_count_q == PCW'(1)) begin
								state_q <= S_EMIT_RD;
							end else begin
								state_q <= S_SORT;
							end
						end
					end
				end
				S_SORT: begin
					if (k_q == nq_q) begin
						state_q <= (nu_q == '0 || np_q == KCW'(1)) ? S_EMIT_RD : S_LEN_RD;
					end
				end
				S_LEN_RD:    state_q <= S_LEN_WAIT;
				S_LEN_WAIT:  state_q <= S_STEP_GO;
				S_STEP_GO:   state_q <= S_STEP_WAIT;
				S_STEP_WAIT: if (md_rsp.done) state_q <= S_PROD_GO;
				S_PROD_GO:   state_q <= S_PROD_WAIT;
				S_PROD_WAIT: if (md_rsp.done) state_q <= S_HI_GO;
				S_HI_GO:     state_q <= S_HI_WAIT;
				S_HI_WAIT:   if (md_rsp.done) state_q <= S_SEARCH;
				S_SEARCH:    state_q <= S_EXTRA;
				S_EXTRA:     if (md_rsp.done) state_q <= S_FILL_GO;
				S_FILL_GO:   state_q <= S_FILL_WAIT;
				S_FILL_WAIT: begin
					if (md_rsp.done) begin
						state_q <= (md_rsp.value >= SAT_PROD) ? S_ACC : S_QDIV_WAIT;
					end
				end
				S_QDIV_WAIT: if (md_rsp.done) state_q <= S_ACC;
				S_ACC: begin
					if (k_q + PCW'(1) < nu_q) begin
						state_q <= S_FILL_GO;
					end else begin
						state_q <= final_q ? S_EMIT_RD : S_SEARCH;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_DEC;
				S_EMIT_DEC: begin
					if (emit) begin
						state_q <= (pk_q + KCW'(1) == np_q) ? S_IDLE : S_EMIT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept_in && mode == MODE_PATH && path_count_q < PCW'(MAX_PATHS)) begin
					p_id_q[path_count_q[PIW-1:0]]    <= path_id;
					p_delay_q[path_count_q[PIW-1:0]] <= path_delay_ms;
					p_rate_q[path_count_q[PIW-1:0]]  <= path_rate_bps;
				end
				np_q    <= pkt_count_q;
				nq_q    <= path_count_q;
				frame_q <= frame_bytes;
				k_q     <= '0;
				nu_q    <= '0;
				pk_q    <= '0;
				h_q     <= '0;
				kind_q  <= K_SINGLE;
			end
			S_SORT: begin
				if (k_q != nq_q) begin
					k_q <= k_q + PCW'(1);
					if (p_rate_q[kidx] != '0) begin
						nu_q <= nu_q + PCW'(1);
						for (int j = 0; j < MAX_PATHS; j++) begin
							if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
								s_id_q[j]    <= s_id_q[(j > 0) ? j - 1 : 0];
								s_delay_q[j] <= s_delay_q[(j > 0) ? j - 1 : 0];
								s_rate_q[j]  <= s_rate_q[(j > 0) ? j - 1 : 0];
							end else if (PCW'(j) == nu_q || gt[j]) begin
								s_id_q[j]    <= p_id_q[kidx];
								s_delay_q[j] <= p_delay_q[kidx];
								s_rate_q[j]  <= p_rate_q[kidx];
							end
						end
					end
				end else begin
					if (nu_q == '0) begin
						kind_q <= K_NONE;
					end else if (np_q == KCW'(1)) begin
						kind_q <= K_FIRST;
					end else begin
						kind_q <= K_DRAIN;
					end
				end
			end
			S_LEN_WAIT: len_first_q <= ram_rdata[15:0];
			S_STEP_WAIT: begin
				if (md_rsp.done) begin
					step_q <= (md_rsp.value[31:0] == '0) ? 32'd1 : md_rsp.value[31:0];
				end
			end
			S_PROD_WAIT: if (md_rsp.done) prod_q <= md_rsp.value[31:0];
			S_HI_WAIT: begin
				if (md_rsp.done) begin
					hi_q <= md_rsp.value[SRCH_W-1:0];
					lo_q <= '0;
				end
			end
			S_SEARCH: begin
				mid_q   <= mid_n;
				final_q <= !(lo_q < hi_q);
				sum_q   <= '0;
				k_q     <= '0;
			end
			S_EXTRA: if (md_rsp.done) extra_q <= md_rsp.value;
			S_FILL_WAIT: if (md_rsp.done) q_q <= QUOTA_MAX;
			S_QDIV_WAIT: if (md_rsp.done) q_q <= md_rsp.value[RECIP_SH +: QUOTA_W];
			S_ACC: begin
				sum_q <= sum_n;
				if (final_q) begin
					quota_q[kidx] <= q_q;
				end
				if (k_q + PCW'(1) < nu_q) begin
					k_q <= k_q + PCW'(1);
				end else if (!final_q) begin
					if (sum_n >= SUM_W'(frame_q)) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + SRCH_W'(1);
					end
				end
			end
			S_EMIT_DEC: begin
				if (skip_path) begin
					h_q <= h_q + PCW'(1);
				end else if (emit) begin
					out_packet_id <= ram_rdata[PKT_W-1:16];
					no_path       <= (kind_q == K_NONE);
					last          <= (pk_q + KCW'(1) == np_q);
					pk_q          <= pk_q + KCW'(1);
					case (kind_q)
						K_SINGLE: out_path_id <= p_id_q[0];
						K_NONE:   out_path_id <= '0;
						K_FIRST:  out_path_id <= s_id_q[0];
						default: begin
							out_path_id <= s_id_q[h_q[PIW-1:0]];
							if (!last_path) begin
								if (keep_path) begin
									quota_q[h_q[PIW-1:0]] <= remain[QUOTA_W-1:0];
								end else begin
									h_q <= h_q + PCW'(1);
								end
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: design/mwfs_ram.sv
// ----------------------------------------------------------------------------
// mwfs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mwfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/mwfs_muldiv.sv
// ----------------------------------------------------------------------------
// mwfs_muldiv
// Shared bit-serial unit: shift-add multiply (a x b, one bit of b per cycle)
// or restoring divide (a / b, one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module mwfs_muldiv
	import mwfs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire md_req_t req,
	output md_rsp_t      rsp
);

	logic                busy_q;
	md_op_t              op_q;
	logic [MD_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   ash_q;
	logic [MUL_B_W-1:0]  bsh_q;
	logic [MUL_A_W-1:0]  num_q;
	logic [MUL_B_W:0]    rem_q;
	logic                done_q;

	logic [MUL_B_W:0] trial;
	logic             fits;

	assign trial = {rem_q[MUL_B_W-1:0], num_q[MUL_A_W-1]};
	assign fits  = trial >= {1'b0, bsh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == MD_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			acc_q <= '0;
			ash_q <= PROD_W'(req.a);
			bsh_q <= req.b;
			num_q <= req.a;
			rem_q <= '0;
			cnt_q <= (req.op == MD_MUL) ? MD_CNT_W'(MUL_B_W) : MD_CNT_W'(MUL_A_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - MD_CNT_W'(1);
			if (op_q == MD_MUL) begin
				if (bsh_q[0]) begin
					acc_q <= acc_q + ash_q;
				end
				ash_q <= {ash_q[PROD_W-2:0], 1'b0};
				bsh_q <= {1'b0, bsh_q[MUL_B_W-1:1]};
			end else begin
				rem_q <= fits ? (trial - {1'b0, bsh_q}) : trial;
				num_q <= {num_q[MUL_A_W-2:0], fits};
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = (op_q == MD_MUL) ? acc_q : PROD_W'(num_q);

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the multipath water-filling scheduler. It loads path and packet
// records, fires go transactions, and checks every packet assignment against a
// behavioral scheduler kept in the testbench. A directed table comes first,
// then random frames, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import mwfs_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam longint unsigned KBYTE = 64'd8000;
	localparam longint unsigned QUOTA_TOP = 64'h1_FFFF_FFFF;
	localparam int RAND_ITEMS = 120;

	typedef struct {
		logic [1:0]  md;
		logic [7:0]  pid;
		logic [15:0] dly;
		logic [31:0] rate;
		logic [31:0] pkt;
		logic [15:0] len;
		logic [23:0] frame;
		bit          typed;      // typed result below applies to every assignment
		logic [7:0]  want_path;
		bit          want_nop;
	} stim_t;

	typedef struct packed {
		logic [31:0] pkt;
		logic [7:0]  path;
		logic        nop;
		logic        lst;
	} assign_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  mode = MODE_NONE;
	logic [7:0]  path_id = '0;
	logic [15:0] path_delay_ms = '0;
	logic [31:0] path_rate_bps = '0;
	logic [31:0] packet_id = '0;
	logic [15:0] packet_bytes = '0;
	logic [23:0] frame_bytes = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [31:0] out_packet_id;
	logic [7:0]  out_path_id;
	logic        no_path;
	logic        last;

	multipath_water_filling_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .path_id(path_id), .path_delay_ms(path_delay_ms),
		.path_rate_bps(path_rate_bps), .packet_id(packet_id),
		.packet_bytes(packet_bytes), .frame_bytes(frame_bytes),
		.result_valid(result_valid), .result_stall(result_stall),
		.out_packet_id(out_packet_id), .out_path_id(out_path_id),
		.no_path(no_path), .last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// scheduler state as seen by the testbench
	logic [7:0]      sch_pid [MAX_PATHS];
	logic [15:0]     sch_dly [MAX_PATHS];
	logic [31:0]     sch_rate[MAX_PATHS];
	longint unsigned sch_quota[MAX_PATHS];
	int              sch_npath = 0;
	logic [31:0]     sch_pkt [MAX_PACKETS];
	logic [15:0]     sch_len [MAX_PACKETS];
	int              sch_npkt = 0;
	int              by_delay[MAX_PATHS];

	assign_t assign_q[$];
	int      errors = 0;
	stim_t   table_rows[$];

	function automatic longint unsigned path_quota(longint unsigned diff, logic [31:0] rate);
		longint unsigned q;
		if (rate == 0 || diff == 0) return 0;
		if (diff > 64'hFFFF_FFFF_FFFF_FFFF / rate) return QUOTA_TOP;
		q = diff * rate / KBYTE;
		return q > QUOTA_TOP ? QUOTA_TOP : q;
	endfunction

	function automatic longint unsigned fill_to(int nu, longint unsigned maxd,
		longint unsigned extra);
		longint unsigned sum = 0;
		int p;
		for (int k = 0; k < nu; k++) begin
			p = by_delay[k];
			sch_quota[p] = path_quota(maxd - sch_dly[p] + extra, sch_rate[p]);
			sum += sch_quota[p];
		end
		return sum;
	endfunction

	function automatic void push_assign(logic [31:0] pkt, logic [7:0] path, bit nop, bit lst);
		assign_t a;
		a.pkt = pkt; a.path = path; a.nop = nop; a.lst = lst;
		assign_q.insert(assign_q.size(), a);
	endfunction

	// drain-based water filling over the loaded tables, then clear them
	function automatic void schedule_frame(logic [23:0] frame_in);
		int np, nq, nu, j, h, p;
		longint unsigned first_len, rate_s, maxd, frame, step, prod, lo, hi, mid, sum;
		longint remain;
		np = sch_npkt; nq = sch_npath;
		sch_npkt = 0; sch_npath = 0;
		if (np == 0) return;
		if (nq == 1) begin
			for (int k = 0; k < np; k++) push_assign(sch_pkt[k], sch_pid[0], 0, k + 1 == np);
			return;
		end
		nu = 0;
		for (int k = 0; k < nq; k++) begin
			if (sch_rate[k] != 0) begin
				j = nu;
				while (j > 0 && sch_dly[by_delay[j-1]] > sch_dly[k]) begin
					by_delay[j] = by_delay[j-1];
					j--;
				end
				by_delay[j] = k;
				nu++;
			end
		end
		if (nu == 0) begin
			for (int k = 0; k < np; k++) push_assign(sch_pkt[k], 8'd0, 1, k + 1 == np);
			return;
		end
		if (np == 1) begin
			push_assign(sch_pkt[0], sch_pid[by_delay[0]], 0, 1);
			return;
		end
		first_len = sch_len[0];
		rate_s = sch_rate[by_delay[nu-1]];
		maxd = sch_dly[by_delay[nu-1]];
		frame = frame_in;
		step = first_len * KBYTE / rate_s;
		if (step == 0) step = 1;
		prod = step * rate_s;
		lo = 0;
		hi = (frame * KBYTE + prod - 1) / prod;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			sum = fill_to(nu, maxd, mid * step);
			if (sum >= frame) hi = mid;
			else lo = mid + 1;
		end
		sum = fill_to(nu, maxd, lo * step);
		h = 0;
		for (int k = 0; k < np; k++) begin
			forever begin
				p = by_delay[h];
				if (h + 1 >= nu) begin
					push_assign(sch_pkt[k], sch_pid[p], 0, k + 1 == np);
					break;
				end
				if (sch_quota[p] > 0) begin
					remain = longint'(sch_quota[p]) - longint'(sch_len[k]);
					push_assign(sch_pkt[k], sch_pid[p], 0, k + 1 == np);
					if (remain >= longint'(first_len)) sch_quota[p] = remain;
					else h++;
					break;
				end
				h++;
			end
		end
	endfunction

	function automatic void accept_item(stim_t s);
		case (s.md)
			MODE_PATH: if (sch_npath < MAX_PATHS) begin
				sch_pid[sch_npath] = s.pid;
				sch_dly[sch_npath] = s.dly;
				sch_rate[sch_npath] = s.rate;
				sch_quota[sch_npath] = 0;
				sch_npath++;
			end
			MODE_PKT: if (sch_npkt < MAX_PACKETS) begin
				sch_pkt[sch_npkt] = s.pkt;
				sch_len[sch_npkt] = s.len;
				sch_npkt++;
			end
			MODE_GO: schedule_frame(s.frame);
			default: ;
		endcase
	endfunction

	// drive one transaction and return at the edge that takes it
	task automatic send_item(stim_t s);
		int before_n;
		mode <= s.md; path_id <= s.pid; path_delay_ms <= s.dly;
		path_rate_bps <= s.rate; packet_id <= s.pkt; packet_bytes <= s.len;
		frame_bytes <= s.frame; item_valid <= 1'b1;
		do @(negedge clk); while (item_stall);
		before_n = assign_q.size();
		accept_item(s);
		if (s.typed) begin
			for (int k = before_n; k < assign_q.size(); k++)
				if (assign_q[k].path !== s.want_path || assign_q[k].nop !== s.want_nop) begin
					$display("%0t typed result: expected path %0d no_path %0d, predicted %0d %0d",
						$time, s.want_path, s.want_nop, assign_q[k].path, assign_q[k].nop);
					errors++;
				end
		end
		@(posedge clk);
	endtask

	int burst_left = 0;

	task automatic pace_sender();
		int g;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 12);
		g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic stim_t mk(logic [1:0] md, logic [7:0] pid, logic [15:0] dly,
		logic [31:0] rate, logic [31:0] pkt, logic [15:0] len, logic [23:0] frame);
		stim_t s;
		s.md = md; s.pid = pid; s.dly = dly; s.rate = rate; s.pkt = pkt; s.len = len;
		s.frame = frame; s.typed = 0; s.want_path = 0; s.want_nop = 0;
		return s;
	endfunction

	function automatic stim_t mk_go(logic [23:0] frame, bit typed, logic [7:0] wp, bit wn);
		stim_t s;
		s = mk(MODE_GO, 8'($urandom), 16'($urandom), $urandom, $urandom, 16'($urandom), frame);
		s.typed = typed; s.want_path = wp; s.want_nop = wn;
		return s;
	endfunction

	function automatic void add_row(stim_t s);
		table_rows.insert(table_rows.size(), s);
	endfunction

	function automatic logic [31:0] rand_rate();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return $urandom_range(1, 100);
			2: return 32'hFFFF_FFFF;
			3: return $urandom;
			default: return $urandom_range(100_000, 50_000_000);
		endcase
	endfunction

	function automatic logic [15:0] rand_delay();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 200));
		endcase
	endfunction

	// receiver stall pattern: alternating calm and busy stretches
	int stall_phase = 0;
	always @(posedge clk) begin
		if (stall_phase == 0) stall_phase <= $urandom_range(5, 60);
		else stall_phase <= stall_phase - 1;
		if ((stall_phase / 20) % 2 == 0) result_stall <= 1'b0;
		else result_stall <= ($urandom_range(0, 2) == 0);
	end

	// result checker
	always @(negedge clk) begin
		assign_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (assign_q.size() == 0) begin
				$display("%0t unexpected transaction: packet %h path %0d no_path %b last %b",
					$time, out_packet_id, out_path_id, no_path, last);
				errors++;
			end else begin
				e = assign_q.pop_front();
				if (out_packet_id !== e.pkt) begin
					$display("%0t out_packet_id: expected %h actual %h", $time, e.pkt, out_packet_id);
					errors++;
				end
				if (out_path_id !== e.path) begin
					$display("%0t out_path_id: expected %0d actual %0d", $time, e.path, out_path_id);
					errors++;
				end
				if (no_path !== e.nop) begin
					$display("%0t no_path: expected %b actual %b", $time, e.nop, no_path);
					errors++;
				end
				if (last !== e.lst) begin
					$display("%0t last: expected %b actual %b", $time, e.lst, last);
					errors++;
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int n_items, npath, npkt;
		logic [31:0] id_base;
		// directed table
		add_row(mk_go(24'd100, 0, 0, 0));             // go with nothing loaded
		add_row(mk(MODE_PATH, 8'hFF, 16'hFFFF, 32'd0, 0, 0, 0));
		add_row(mk(MODE_PKT, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 0));
		add_row(mk(MODE_PKT, 0, 0, 0, 32'd0, 16'd0, 0));
		add_row(mk_go(24'hFF_FFFF, 1, 8'hFF, 0));     // lone path, even at rate 0
		add_row(mk(MODE_PATH, 8'd1, 16'd10, 32'd0, 0, 0, 0));
		add_row(mk(MODE_PATH, 8'd2, 16'd20, 32'd0, 0, 0, 0));
		add_row(mk(MODE_PKT, 0, 0, 0, 32'd5, 16'd100, 0));
		add_row(mk(MODE_PKT, 0, 0, 0, 32'd6, 16'd100, 0));
		add_row(mk_go(24'd500, 1, 8'd0, 1));          // every rate zero
		add_row(mk(MODE_PATH, 8'd3, 16'd50, 32'd1_000_000, 0, 0, 0));
		add_row(mk(MODE_PATH, 8'd4, 16'd10, 32'd2_000_000, 0, 0, 0));
		add_row(mk(MODE_PATH, 8'd7, 16'd10, 32'd5, 0, 0, 0));
		add_row(mk(MODE_PKT, 0, 0, 0, 32'd9, 16'd1200, 0));
		add_row(mk_go(24'd0, 1, 8'd4, 0));            // one packet, lowest delay, tie order
		add_row(mk(MODE_NONE, 8'hAA, 16'h5555, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hAAAA,
			24'h55_5555));
		add_row(mk(MODE_PATH, 8'h10, 16'd30, 32'd8_000_000, 0, 0, 0));
		add_row(mk(MODE_PATH, 8'h20, 16'd5, 32'hFFFF_FFFF, 0, 0, 0));
		add_row(mk(MODE_PATH, 8'h30, 16'd0, 32'd0, 0, 0, 0));
		add_row(mk(MODE_PATH, 8'h40, 16'd30, 32'd1, 0, 0, 0));
		add_row(mk(MODE_PATH, 8'h50, 16'd1, 32'd99, 0, 0, 0));  // table full
		for (int k = 0; k < 4; k++)
			add_row(mk(MODE_PKT, 0, 0, 0, 32'(100 + k), 16'(400 * (k + 1)), 0));
		add_row(mk_go(24'd3000, 0, 0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			send_item(table_rows[i]);
			pace_sender();
		end

		// random frames
		n_items = 0;
		while (n_items < RAND_ITEMS) begin
			npath = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(2, 4);
			case ($urandom_range(0, 19))
				0: npkt = 0;
				1: npkt = 1;
				2: npkt = $urandom_range(64, 66);
				default: npkt = $urandom_range(2, 8);
			endcase
			for (int k = 0; k < npath; k++) begin
				send_item(mk(MODE_PATH, 8'($urandom), rand_delay(), rand_rate(), $urandom,
					16'($urandom), 24'($urandom)));
				pace_sender();
				if (k < MAX_PATHS) n_items++;
			end
			id_base = $urandom;
			for (int k = 0; k < npkt; k++) begin
				send_item(mk(MODE_PKT, 8'($urandom), 16'($urandom), $urandom, id_base + k,
					($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500)),
					24'($urandom)));
				pace_sender();
				if (k < MAX_PACKETS) n_items++;
			end
			if ($urandom_range(0, 7) == 0) begin
				send_item(mk(MODE_NONE, 8'($urandom), 16'($urandom), $urandom, $urandom,
					16'($urandom), 24'($urandom)));
				pace_sender();
			end
			send_item(mk_go(($urandom_range(0, 4) == 0) ? 24'($urandom) :
				24'($urandom_range(0, 20000)), 0, 0, 0));
			n_items++;
			pace_sender();
		end
		item_valid <= 1'b0;

		while (assign_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
design/mwfs_pkg.sv
design/mwfs_ram.sv
design/mwfs_muldiv.sv
design/multipath_water_filling_scheduler.sv
test/tb_top.sv
